// ===== hw/rtl/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared constants and controller/datapath interface types for the
// first-match pattern search block.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int IDX_BITS    = $clog2(PATTERN_MAX);
    localparam int CNT_BITS    = $clog2(PATTERN_MAX + 1);
    localparam int POS_BITS    = 32;
    localparam int BYTE_BITS   = 8;

    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_TEXT    = 1'b1;

    typedef struct packed {
        logic accept;
        logic rd;
        logic cmp;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic start_walk;
        logic kp_zero;
        logic byte_eq;
        logic need_res;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/kmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmp_ctrl
// Sequencer for the border walk: accept, table read, compare, commit.
// ----------------------------------------------------------------------------
module kmp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  kmp_pkg::t_sts i_sts,
    output kmp_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    import kmp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CMP  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.start_walk) n_state = S_RD;
                end
            end
            S_RD: begin
                // offset-encoded index zero means border of minus one: walk ends
                if (i_sts.kp_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.byte_eq ? S_FIN : S_RD;
            end
            S_FIN: begin
                if (!i_sts.need_res || i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_commit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_state == S_IDLE)
        else $error("commit did not return to idle");

    a_walk_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept && i_sts.start_walk |=> r_state == S_RD)
        else $error("walk start lost");

endmodule

// ===== hw/rtl/kmp_dpath.sv =====
// ----------------------------------------------------------------------------
// kmp_dpath
// Pattern store, border table, match state, text position and result register.
// ----------------------------------------------------------------------------
module kmp_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kmp_pkg::t_cmd                    i_cmd,
    output kmp_pkg::t_sts                    o_sts,
    input  logic                             i_req_type,
    input  logic [kmp_pkg::BYTE_BITS-1:0]    i_data_byte,
    input  logic                             i_first_byte,
    input  logic                             i_last_byte,
    input  logic                             i_cfg_valid,
    input  logic [kmp_pkg::POS_BITS-1:0]     i_cfg_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_found,
    output logic [kmp_pkg::POS_BITS-1:0]     o_match_pos
);
    import kmp_pkg::*;

    logic [BYTE_BITS-1:0] store_mem [PATTERN_MAX];
    logic [IDX_BITS-1:0]  bord_mem  [PATTERN_MAX];

    logic                 r_req;
    logic [BYTE_BITS-1:0] r_byte;
    logic                 r_last;
    logic [CNT_BITS-1:0]  r_pat_cnt;
    logic [CNT_BITS-1:0]  r_build_kp;   // build border plus one
    logic [IDX_BITS-1:0]  r_match_len;
    logic [POS_BITS-1:0]  r_text_idx;
    logic                 r_done;
    logic [POS_BITS-1:0]  r_start_pos;
    logic [CNT_BITS-1:0]  r_kp;         // walk index plus one, zero is minus one
    logic [BYTE_BITS-1:0] r_store_q;
    logic [IDX_BITS-1:0]  r_bord_q;
    logic                 r_out_valid;
    logic                 r_found;
    logic [POS_BITS-1:0]  r_pos;

    logic [CNT_BITS-1:0]  w_eff_cnt;
    logic [CNT_BITS-1:0]  w_eff_bkp;
    logic                 w_eff_done;
    logic [IDX_BITS-1:0]  w_eff_ml;
    logic [POS_BITS-1:0]  w_eff_idx;
    logic                 w_pat_full;
    logic                 w_pat_empty;
    logic [CNT_BITS-1:0]  w_rd_addr;
    logic [CNT_BITS-1:0]  w_cnt_inc;
    logic                 w_hit;

    assign w_eff_cnt   = i_first_byte ? '0 : r_pat_cnt;
    assign w_eff_bkp   = i_first_byte ? '0 : r_build_kp;
    assign w_eff_done  = i_first_byte ? 1'b0 : r_done;
    assign w_eff_ml    = i_first_byte ? '0 : r_match_len;
    assign w_eff_idx   = i_first_byte ? r_start_pos : r_text_idx;
    assign w_pat_full  = (w_eff_cnt == CNT_BITS'(PATTERN_MAX));
    assign w_pat_empty = (r_pat_cnt == '0);
    assign w_rd_addr   = r_kp - 1'b1;
    assign w_cnt_inc   = r_pat_cnt + 1'b1;
    assign w_hit       = (r_kp >= r_pat_cnt);

    always_comb begin
        o_sts            = '0;
        o_sts.start_walk = (i_req_type == REQ_PATTERN) ? !w_pat_full : !w_eff_done;
        o_sts.kp_zero    = (r_kp == '0);
        o_sts.byte_eq    = (r_byte == r_store_q);
        o_sts.need_res   = (r_req == REQ_TEXT) && (w_hit || r_last);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // memories: no reset, entries are read only below the pattern count
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_req_type == REQ_PATTERN && !w_pat_full) begin
            store_mem[w_eff_cnt[IDX_BITS-1:0]] <= i_data_byte;
        end
        // the entry past capacity wraps onto entry zero, whose read value is never used
        if (i_cmd.commit && r_req == REQ_PATTERN) begin
            bord_mem[w_cnt_inc[IDX_BITS-1:0]] <= r_kp[IDX_BITS-1:0];
        end
        if (i_cmd.rd) begin
            r_store_q <= store_mem[w_rd_addr[IDX_BITS-1:0]];
            r_bord_q  <= bord_mem[w_rd_addr[IDX_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req  <= i_req_type;
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
        if (i_cmd.commit && o_sts.need_res) begin
            r_found <= w_hit;
            r_pos   <= w_hit ? r_text_idx - POS_BITS'(r_pat_cnt) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_cnt   <= '0;
            r_build_kp  <= '0;
            r_match_len <= '0;
            r_text_idx  <= '0;
            r_done      <= 1'b0;
            r_start_pos <= '0;
            r_kp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_start_pos <= i_cfg_data;

            if (i_cmd.accept) begin
                if (i_req_type == REQ_PATTERN) begin
                    r_pat_cnt   <= w_eff_cnt;
                    r_build_kp  <= w_eff_bkp;
                    r_kp        <= w_eff_bkp;
                    r_done      <= 1'b1;
                    r_match_len <= '0;
                end else begin
                    if (i_first_byte) begin
                        r_match_len <= '0;
                        r_done      <= 1'b0;
                    end
                    // a first byte always starts a walk, which loads the start index
                    if (!w_eff_done) begin
                        // empty pattern matches at the current index, no advance
                        r_kp       <= w_pat_empty ? '0 : CNT_BITS'(w_eff_ml) + 1'b1;
                        r_text_idx <= w_eff_idx + POS_BITS'(!w_pat_empty);
                    end
                end
            end

            if (i_cmd.cmp && !o_sts.byte_eq) begin
                r_kp <= (r_kp == CNT_BITS'(1)) ? '0 : CNT_BITS'(r_bord_q) + 1'b1;
            end

            if (i_cmd.commit) begin
                if (r_req == REQ_PATTERN) begin
                    r_pat_cnt  <= w_cnt_inc;
                    r_build_kp <= r_kp + 1'b1;
                end else if (w_hit) begin
                    r_done      <= 1'b1;
                    r_match_len <= '0;
                end else begin
                    r_match_len <= r_kp[IDX_BITS-1:0];
                    if (r_last) r_done <= 1'b1;
                end
            end

            if (i_cmd.commit && o_sts.need_res) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_match_pos = r_pos;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && o_sts.need_res |-> !r_out_valid || i_out_ready)
        else $error("result overwrote a pending beat");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pat_cnt <= CNT_BITS'(PATTERN_MAX))
        else $error("pattern count past capacity");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> r_kp <= r_pat_cnt)
        else $error("walk index beyond stored pattern");

endmodule

// ===== hw/rtl/kmp_first_match_search.sv =====
// ----------------------------------------------------------------------------
// kmp_first_match_search
// First-match byte pattern search over a streamed text with border tables.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one byte per beat: pattern
// bytes (i_req_type 0) build the pattern and its border table, text bytes
// (i_req_type 1) run the matcher. i_first_byte restarts the pattern or the
// search; i_last_byte ends a search. Pattern bytes past 64 are dropped.
// The config channel (i_cfg_valid / o_cfg_ready) sets the start position of
// the first text byte; write it only while the block is idle.
// Output channel (o_out_valid / i_out_ready) gives at most one beat per search:
// o_found 1 with the match start, or o_found 0 and position zero at the end.
// Sequence: an item passes an accept state, then for each border-walk step a
// registered read of the pattern store and border table and a compare, and
// then a commit state; a walk that ends at border minus one passes the read
// state once more without reading.
// Fallbacks amortize to under one per text byte.
// o_in_ready is high only between items.
// Reset empties the pattern, clears the search state and the start position.
// The result register holds a beat until taken; new items are still accepted,
// and an item that produces a result waits in its commit cycle if the
// previous beat is still pending.
// ----------------------------------------------------------------------------
module kmp_first_match_search (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_req_type,
    input  logic [kmp_pkg::BYTE_BITS-1:0]    i_data_byte,
    input  logic                             i_first_byte,
    input  logic                             i_last_byte,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kmp_pkg::POS_BITS-1:0]     i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_found,
    output logic [kmp_pkg::POS_BITS-1:0]     o_match_pos
);
    import kmp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    kmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    kmp_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_req_type   (i_req_type),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_found      (o_found),
        .o_match_pos  (o_match_pos)
    );

endmodule
